>>> rtl/core/wfs_pkg.sv
// ----------------------------------------------------------------------------
// wfs_pkg: shared types and constants for the wire-following steering block
// Widths, fixed-point constants, register indexes and drive mode codes.
// ----------------------------------------------------------------------------
package wfs_pkg;

  // Sensor magnitude width (8 to 16) and the pivot boost added to the inner wheel.
  localparam int MAG_WIDTH    = 13;
  localparam int PIVOT_OFFSET = 220;

  localparam int GAIN_W   = 12;
  localparam int TARGET_W = 13;
  localparam int ERR_W    = 14;
  localparam int ABS_W    = ERR_W - 1;
  localparam int PROD_W   = ABS_W + GAIN_W;
  localparam int PWM_W    = 8;
  localparam int COUNT_W  = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 13;

  // Error is formed wide enough for either operand and then clamped.
  localparam int ERR_CALC_W = ((MAG_WIDTH > TARGET_W) ? MAG_WIDTH : TARGET_W) + 1;
  localparam int ERR_LIMIT  = 8191;

  localparam logic [PWM_W-1:0]  PWM_FULL   = 8'd255;
  // Full scale inner duty in Q.8: 255 * 256.
  localparam logic [PROD_W-1:0] FULL_SCALE = PROD_W'(255 * 256);

  localparam logic [GAIN_W-1:0]  GAIN_RESET       = 12'd307;
  localparam logic [COUNT_W-1:0] MAX_TURNS_RESET  = 8'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN      = 3'd0,
    REG_TARGET    = 3'd1,
    REG_CLOCKWISE = 3'd2,
    REG_MAX_LEFT  = 3'd3,
    REG_MAX_RIGHT = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DRIVE_FORWARD = 2'd0,
    PIVOT_LEFT    = 2'd1,
    PIVOT_RIGHT   = 2'd2
  } drive_mode_t;

  typedef struct packed {
    logic [PWM_W-1:0]        left_pwm;
    logic [PWM_W-1:0]        pwm_right;
    drive_mode_t             drive_mode;
    logic                    left_inner;
    logic signed [ERR_W-1:0] tracking_error;
  } steer_t;

endpackage

>>> rtl/core/wfs_steer.sv
// ----------------------------------------------------------------------------
// wfs_steer: proportional wheel duty calculation
// Forms the clamped tracking error, picks the inner wheel and works out its
// duty, including the pivot case when the correction exceeds full scale.
// ----------------------------------------------------------------------------
module wfs_steer
  import wfs_pkg::*;
(
  input  logic signed [MAG_WIDTH-1:0] magnitude,
  input  logic signed [TARGET_W-1:0]  target_magnitude,
  input  logic [GAIN_W-1:0]           gain_q8,
  input  logic                        clockwise_mode,
  output steer_t                      steer
);

  localparam logic signed [ERR_CALC_W-1:0] ERR_MAX = ERR_CALC_W'(ERR_LIMIT);
  localparam logic signed [ERR_CALC_W-1:0] ERR_MIN = ERR_CALC_W'(-ERR_LIMIT);

  logic signed [ERR_CALC_W-1:0] err_wide;
  logic signed [ERR_W-1:0]      err;
  logic [ABS_W-1:0]             abs_err;
  logic [PROD_W-1:0]            prod;
  logic [PROD_W-1:0]            fwd;
  logic [PROD_W-1:0]            over;
  logic [PROD_W-9:0]            over_q;
  logic [PROD_W-9:0]            boosted;
  logic [PWM_W-1:0]             inner;
  logic                         pivot;
  logic                         left_inner;

  always_comb begin
    err_wide = ERR_CALC_W'(target_magnitude) - ERR_CALC_W'(magnitude);
    if (err_wide > ERR_MAX) begin
      err = ERR_W'(ERR_LIMIT);
    end else if (err_wide < ERR_MIN) begin
      err = ERR_W'(-ERR_LIMIT);
    end else begin
      err = err_wide[ERR_W-1:0];
    end
    abs_err = err[ERR_W-1] ? ABS_W'(-err) : err[ABS_W-1:0];

    prod    = PROD_W'(abs_err) * PROD_W'(gain_q8);
    fwd     = FULL_SCALE - prod;
    over    = prod - FULL_SCALE;
    over_q  = over[PROD_W-1:8];
    boosted = over_q + (PROD_W-8)'(PIVOT_OFFSET);

    // A negative raw duty whose magnitude truncates to zero still counts as forward.
    pivot = 1'b0;
    if (prod <= FULL_SCALE) begin
      inner = fwd[15:8];
    end else if (over_q == '0) begin
      inner = '0;
    end else begin
      pivot = 1'b1;
      inner = (boosted > (PROD_W-8)'(PWM_FULL)) ? PWM_FULL : boosted[PWM_W-1:0];
    end

    left_inner = (err > 0) ? clockwise_mode : !clockwise_mode;

    steer.tracking_error = err;
    steer.left_inner     = left_inner;
    if (left_inner) begin
      steer.left_pwm   = inner;
      steer.pwm_right  = PWM_FULL;
      steer.drive_mode = pivot ? PIVOT_LEFT : DRIVE_FORWARD;
    end else begin
      steer.left_pwm   = PWM_FULL;
      steer.pwm_right  = inner;
      steer.drive_mode = pivot ? PIVOT_RIGHT : DRIVE_FORWARD;
    end
  end

endmodule

>>> rtl/core/wire_following_steering.sv
// ----------------------------------------------------------------------------
// wire_following_steering: proportional steering for perimeter wire following
// Turns one sensor magnitude per beat into wheel duties, a drive mode and a
// lost-wire flag.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (magnitude, restart) are taken when in_valid is high and
//   in_stall is low. Each input beat gives exactly one output beat
//   (left_pwm, pwm_right, drive_mode, lost_wire, tracking_error), taken when
//   out_valid is high and out_stall is low.
//   An accepted beat lands in an input register; the steering logic and the
//   turn counters update as it moves into the output register, and out_valid
//   rises as the beat is registered there. One beat per cycle is sustained
//   while out_stall is low; the single multiply between the two registers
//   sets the clock limit.
//   When out_stall is held, the output beat holds, one more beat waits in the
//   input register, and in_stall then rises until the output drains.
//   Registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data;
//   cfg_ready is always high and writes to unknown indexes are ignored.
//   Reset (rst, synchronous) empties the pipeline, clears both turn counters
//   and loads the register defaults (gain 307, target 0, clockwise, limits 50).
// ----------------------------------------------------------------------------
module wire_following_steering
  import wfs_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [MAG_WIDTH-1:0] magnitude,
  input  logic                        restart,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [PWM_W-1:0]            left_pwm,
  output logic [PWM_W-1:0]            pwm_right,
  output logic [1:0]                  drive_mode,
  output logic                        lost_wire,
  output logic signed [ERR_W-1:0]     tracking_error,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  logic [GAIN_W-1:0]          gain_q8;
  logic signed [TARGET_W-1:0] target_magnitude;
  logic                       clockwise_mode;
  logic [COUNT_W-1:0]         max_left_turns;
  logic [COUNT_W-1:0]         max_right_turns;

  logic                        s1_valid;
  logic signed [MAG_WIDTH-1:0] s1_magnitude;
  logic                        s1_restart;
  logic                        s1_move;
  logic                        in_accept;

  logic [COUNT_W-1:0] left_count;
  logic [COUNT_W-1:0] right_count;
  logic [COUNT_W-1:0] left_count_next;
  logic [COUNT_W-1:0] right_count_next;
  logic               lost_next;

  steer_t steer;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_q8          <= GAIN_RESET;
      target_magnitude <= '0;
      clockwise_mode   <= 1'b1;
      max_left_turns   <= MAX_TURNS_RESET;
      max_right_turns  <= MAX_TURNS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GAIN:      gain_q8          <= cfg_data[GAIN_W-1:0];
        REG_TARGET:    target_magnitude <= cfg_data[TARGET_W-1:0];
        REG_CLOCKWISE: clockwise_mode   <= cfg_data[0];
        REG_MAX_LEFT:  max_left_turns   <= cfg_data[COUNT_W-1:0];
        REG_MAX_RIGHT: max_right_turns  <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // The input register moves on whenever the output register is empty or draining.
  assign s1_move   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_magnitude <= magnitude;
      s1_restart   <= restart;
    end
  end

  wfs_steer u_steer (
    .magnitude        (s1_magnitude),
    .target_magnitude (target_magnitude),
    .gain_q8          (gain_q8),
    .clockwise_mode   (clockwise_mode),
    .steer            (steer)
  );

  always_comb begin
    left_count_next  = s1_restart ? '0 : left_count;
    right_count_next = s1_restart ? '0 : right_count;
    if (steer.left_inner) begin
      right_count_next = '0;
      if (left_count_next != '1) begin
        left_count_next = left_count_next + 1'b1;
      end
    end else begin
      left_count_next = '0;
      if (right_count_next != '1) begin
        right_count_next = right_count_next + 1'b1;
      end
    end
    lost_next = (left_count_next > max_left_turns) || (right_count_next > max_right_turns);
    if (lost_next) begin
      left_count_next  = '0;
      right_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_count  <= '0;
      right_count <= '0;
    end else if (s1_move) begin
      left_count  <= left_count_next;
      right_count <= right_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      left_pwm       <= steer.left_pwm;
      pwm_right      <= steer.pwm_right;
      drive_mode     <= steer.drive_mode;
      lost_wire      <= lost_next;
      tracking_error <= steer.tracking_error;
    end
  end

  // Only one side can ever be counting consecutive turns.
  a_one_side_counts: assert property (@(posedge clk) disable iff (rst)
    !((left_count != '0) && (right_count != '0)))
    else $error("both turn counters non-zero");

  a_lost_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_move && lost_next) |=> ((left_count == '0) && (right_count == '0)))
    else $error("turn counters not cleared after lost wire");

  a_pivot_left_outer: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (drive_mode == PIVOT_LEFT)) |->
      ((pwm_right == PWM_FULL) && (left_pwm >= PWM_W'(PIVOT_OFFSET))))
    else $error("left pivot with wrong wheel duties");

  a_pivot_right_outer: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (drive_mode == PIVOT_RIGHT)) |->
      ((left_pwm == PWM_FULL) && (pwm_right >= PWM_W'(PIVOT_OFFSET))))
    else $error("right pivot with wrong wheel duties");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && out_stall) |=> (s1_valid && out_valid))
    else $error("beat dropped while the output was stalled");

endmodule
